/* rtl/timer_counter_8bit_pwm_unit_defines.svh */
// ----------------------------------------------------------------------------
// timer_counter_8bit_pwm_unit_defines
// assertion macros used by the timer/counter core
// ----------------------------------------------------------------------------
`ifndef TIMER_COUNTER_8BIT_PWM_UNIT_DEFINES_SVH
`define TIMER_COUNTER_8BIT_PWM_UNIT_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, disabled during reset
`define TC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer/counter assertion failed");

// next-cycle implication, disabled during reset
`define TC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer/counter assertion failed");

`else

`define TC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/tcpwm_pkg.sv */
// ----------------------------------------------------------------------------
// tcpwm_pkg
// types, codes and helpers for the 8-bit timer/counter with pwm output
// ----------------------------------------------------------------------------
package tcpwm_pkg;

    localparam int CNT_W     = 8;
    localparam int PRESC_W   = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 3;

    localparam logic [CNT_W-1:0] CNT_MAX    = 8'hFF;
    localparam logic [CNT_W-1:0] CNT_BOTTOM = 8'h00;

    // item operations
    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_WR_COUNT   = 3'd1,
        OP_WR_COMPARE = 3'd2,
        OP_READ       = 3'd3,
        OP_START      = 3'd4,
        OP_STOP       = 3'd5
    } op_e;

    // waveform modes
    typedef enum logic [1:0] {
        WM_NORMAL = 2'd0,
        WM_PHASE  = 2'd1,
        WM_CTC    = 2'd2,
        WM_FAST   = 2'd3
    } wave_mode_e;

    // compare output actions
    typedef enum logic [1:0] {
        PA_OFF    = 2'd0,
        PA_TOGGLE = 2'd1,
        PA_CLEAR  = 2'd2,
        PA_SET    = 2'd3
    } pin_action_e;

    // clock sources
    typedef enum logic [2:0] {
        CS_NONE     = 3'd0,
        CS_DIV1     = 3'd1,
        CS_DIV8     = 3'd2,
        CS_DIV64    = 3'd3,
        CS_DIV256   = 3'd4,
        CS_DIV1024  = 3'd5,
        CS_EXT_FALL = 3'd6,
        CS_EXT_RISE = 3'd7
    } clock_sel_e;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAVE_MODE    = 3'd0,
        CFG_PIN_ACTION   = 3'd1,
        CFG_CLOCK_SELECT = 3'd2,
        CFG_OVF_IRQ_EN   = 3'd3,
        CFG_MATCH_IRQ_EN = 3'd4
    } cfg_index_e;

    typedef struct packed {
        logic [1:0] wave_mode;
        logic [1:0] pin_action;
        logic [2:0] clock_select;
        logic       overflow_irq_enable;
        logic       match_irq_enable;
    } cfg_t;

    typedef struct packed {
        logic [2:0]       op;
        logic [CNT_W-1:0] data;
        logic             ext_pin;
    } in_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] count_value;
        logic             wave_pin;
        logic             overflow_irq;
        logic             match_irq;
    } out_item_t;

    // low prescaler bits that must be zero for a counter advance
    function automatic logic [PRESC_W-1:0] presc_mask(input logic [2:0] cs);
        logic [PRESC_W-1:0] m;
        begin
            case (cs)
                CS_DIV8:    m = 10'h007;
                CS_DIV64:   m = 10'h03F;
                CS_DIV256:  m = 10'h0FF;
                CS_DIV1024: m = 10'h3FF;
                default:    m = 10'h000;
            endcase
            return m;
        end
    endfunction

endpackage

/* rtl/tcpwm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// tcpwm_cfg_regs
// configuration register file written through the plain write port
// ----------------------------------------------------------------------------
module tcpwm_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [tcpwm_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [tcpwm_pkg::CFG_DAT_W-1:0] wr_data,
    output tcpwm_pkg::cfg_t                cfg
);
    import tcpwm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register decode, out-of-range indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_WAVE_MODE:    cfg_next.wave_mode           = wr_data[1:0];
                CFG_PIN_ACTION:   cfg_next.pin_action          = wr_data[1:0];
                CFG_CLOCK_SELECT: cfg_next.clock_select        = wr_data;
                CFG_OVF_IRQ_EN:   cfg_next.overflow_irq_enable = wr_data[0];
                CFG_MATCH_IRQ_EN: cfg_next.match_irq_enable    = wr_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/tcpwm_in_reg.sv */
// ----------------------------------------------------------------------------
// tcpwm_in_reg
// input register stage, holds one item until the core takes it
// ----------------------------------------------------------------------------
module tcpwm_in_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  tcpwm_pkg::in_item_t  in_item,
    input  logic                 take_ok,
    output logic                 item_valid,
    output tcpwm_pkg::in_item_t  item
);
    import tcpwm_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // stall only while a held item cannot move on
    assign in_stall   = valid_reg && !take_ok;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture on a transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/tcpwm_core.sv */
// ----------------------------------------------------------------------------
// tcpwm_core
// timer state, prescaler, waveform modes and compare output for one item
// ----------------------------------------------------------------------------
`include "timer_counter_8bit_pwm_unit_defines.svh"

module tcpwm_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcpwm_pkg::cfg_t      cfg,
    input  logic                 fire,
    input  tcpwm_pkg::in_item_t  item,
    output tcpwm_pkg::out_item_t res
);
    import tcpwm_pkg::*;

    logic [CNT_W-1:0]   count_reg,    count_next;
    logic [CNT_W-1:0]   compare_reg,  compare_next;
    logic [PRESC_W-1:0] prescale_reg, prescale_next;
    logic               down_reg,     down_next;
    logic               pin_reg,      pin_next;
    logic               run_reg,      run_next;
    logic               last_ext_reg, last_ext_next;

    logic [PRESC_W-1:0] presc_inc;
    logic               presc_used;
    logic               tick_clk;

    logic               dir_pre;
    logic [CNT_W-1:0]   adv_count;
    logic               adv_down;
    logic               adv_pin;
    logic               adv_ovf;
    logic               adv_match;

    logic               ovf_evt;
    logic               match_evt;
    logic               pin_connected;

    // clock source selection and prescaler
    assign presc_inc  = prescale_reg + 10'd1;
    assign presc_used = (cfg.clock_select != CS_NONE) && (cfg.clock_select != CS_EXT_FALL)
                        && (cfg.clock_select != CS_EXT_RISE);

    always_comb
    begin
        case (cfg.clock_select)
            CS_NONE:     tick_clk = 1'b0;
            CS_EXT_FALL: tick_clk = last_ext_reg && !item.ext_pin;
            CS_EXT_RISE: tick_clk = !last_ext_reg && item.ext_pin;
            default:     tick_clk = ((presc_inc & presc_mask(cfg.clock_select)) == '0);
        endcase
        tick_clk = tick_clk && run_reg;
    end

    // one counter advance in the selected waveform mode
    always_comb
    begin
        dir_pre   = down_reg;
        adv_count = count_reg + 8'd1;
        adv_down  = down_reg;
        adv_pin   = pin_reg;
        adv_ovf   = 1'b0;
        adv_match = 1'b0;
        if (cfg.wave_mode == WM_PHASE)
        begin
            // turn around at top or bottom, also after a counter write
            if (!down_reg && count_reg == CNT_MAX)
            begin
                dir_pre = 1'b1;
            end
            else if (down_reg && count_reg == CNT_BOTTOM)
            begin
                dir_pre = 1'b0;
            end
            adv_count = dir_pre ? count_reg - 8'd1 : count_reg + 8'd1;
            adv_down  = dir_pre;
            if (adv_count == CNT_MAX)
            begin
                adv_down = 1'b1;
            end
            if (adv_count == CNT_BOTTOM)
            begin
                adv_down = 1'b0;
                adv_ovf  = 1'b1;
            end
            adv_match = (adv_count == compare_reg);
            if (adv_match)
            begin
                case (cfg.pin_action)
                    PA_CLEAR: adv_pin = adv_down;
                    PA_SET:   adv_pin = !adv_down;
                    default:  adv_pin = pin_reg;
                endcase
            end
        end
        else
        begin
            if (cfg.wave_mode == WM_CTC && count_reg == compare_reg)
            begin
                adv_count = CNT_BOTTOM;
            end
            // wrap at top, fast pwm restarts the output period here
            if (count_reg == CNT_MAX)
            begin
                adv_ovf = 1'b1;
                if (cfg.wave_mode == WM_FAST)
                begin
                    if (cfg.pin_action == PA_CLEAR)
                    begin
                        adv_pin = 1'b1;
                    end
                    else if (cfg.pin_action == PA_SET)
                    begin
                        adv_pin = 1'b0;
                    end
                end
            end
            adv_match = (adv_count == compare_reg);
            if (adv_match)
            begin
                if (cfg.wave_mode == WM_FAST)
                begin
                    if (cfg.pin_action == PA_CLEAR)
                    begin
                        adv_pin = 1'b0;
                    end
                    else if (cfg.pin_action == PA_SET)
                    begin
                        adv_pin = 1'b1;
                    end
                end
                else
                begin
                    case (cfg.pin_action)
                        PA_TOGGLE: adv_pin = !adv_pin;
                        PA_CLEAR:  adv_pin = 1'b0;
                        PA_SET:    adv_pin = 1'b1;
                        default:   adv_pin = adv_pin;
                    endcase
                end
            end
        end
    end

    // operation decode and next state
    always_comb
    begin
        count_next    = count_reg;
        compare_next  = compare_reg;
        prescale_next = prescale_reg;
        down_next     = down_reg;
        pin_next      = pin_reg;
        run_next      = run_reg;
        last_ext_next = last_ext_reg;
        ovf_evt       = 1'b0;
        match_evt     = 1'b0;
        if (fire)
        begin
            unique case (item.op)
                OP_TICK:
                begin
                    last_ext_next = item.ext_pin;
                    if (run_reg && presc_used)
                    begin
                        prescale_next = presc_inc;
                    end
                    if (tick_clk)
                    begin
                        count_next = adv_count;
                        down_next  = adv_down;
                        pin_next   = adv_pin;
                        ovf_evt    = adv_ovf;
                        match_evt  = adv_match;
                    end
                end
                OP_WR_COUNT:   count_next = item.data;
                OP_WR_COMPARE: compare_next = item.data;
                OP_START:
                begin
                    run_next      = 1'b1;
                    prescale_next = '0;
                end
                OP_STOP:       run_next = 1'b0;
                default:       count_next = count_reg;
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            compare_reg  <= '0;
            prescale_reg <= '0;
            down_reg     <= 1'b0;
            pin_reg      <= 1'b0;
            run_reg      <= 1'b0;
            last_ext_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            compare_reg  <= compare_next;
            prescale_reg <= prescale_next;
            down_reg     <= down_next;
            pin_reg      <= pin_next;
            run_reg      <= run_next;
            last_ext_reg <= last_ext_next;
        end
    end

    // result for this item, pin reads low when disconnected
    assign pin_connected = (cfg.pin_action != PA_OFF)
                           && !((cfg.wave_mode == WM_PHASE || cfg.wave_mode == WM_FAST)
                                && cfg.pin_action == PA_TOGGLE);

    assign res.count_value  = count_next;
    assign res.wave_pin     = pin_connected && pin_next;
    assign res.overflow_irq = ovf_evt && cfg.overflow_irq_enable;
    assign res.match_irq    = match_evt && cfg.match_irq_enable;

    // checks
    `TC_ASSERT_NEXT(a_count_write, clk, rst_n, fire && item.op == OP_WR_COUNT, count_reg == $past(item.data))
    `TC_ASSERT_NEXT(a_stop_halts, clk, rst_n, fire && item.op == OP_STOP, !run_reg)
    `TC_ASSERT_NEXT(a_start_clears, clk, rst_n, fire && item.op == OP_START, run_reg && prescale_reg == '0)
    `TC_ASSERT_IMP(a_irq_tick_only, clk, rst_n, fire && item.op != OP_TICK, !res.overflow_irq && !res.match_irq)

endmodule

/* rtl/tcpwm_out_reg.sv */
// ----------------------------------------------------------------------------
// tcpwm_out_reg
// result register, holds one result until the consumer takes it
// ----------------------------------------------------------------------------
module tcpwm_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  tcpwm_pkg::out_item_t  res,
    output logic                  take_ok,
    output logic                  out_valid,
    input  logic                  out_stall,
    output tcpwm_pkg::out_item_t  out_item
);
    import tcpwm_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t res_reg;

    // free when empty or when the held result transfers this cycle
    assign take_ok    = !valid_reg || !out_stall;
    assign valid_next = take_ok ? item_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result capture
    always_ff @(posedge clk)
    begin
        if (take_ok && item_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = res_reg;

endmodule

/* rtl/timer_counter_8bit_pwm_unit.sv */
// ----------------------------------------------------------------------------
// timer_counter_8bit_pwm_unit
// 8-bit timer/counter with prescaler, four waveform modes and compare output
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  in_data   (op, data, ext_pin)
//   out       output     out_valid / out_stall out_data (count, pin, irqs)
//   config    input      wr_en                wr_index, wr_data
//
// one item per cycle sustained while out_stall is low; an item is held in
// the input register and then appears at the result register
// the timer state update is one pass of logic from input to result register
// rst_n clears the configuration, the timer state and both valid flags
// out_stall holds the result register; in_stall rises only when the input
// register is also full
// ----------------------------------------------------------------------------
module timer_counter_8bit_pwm_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  tcpwm_pkg::in_item_t             in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output tcpwm_pkg::out_item_t            out_data,
    input  logic                            wr_en,
    input  logic [tcpwm_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [tcpwm_pkg::CFG_DAT_W-1:0] wr_data
);
    import tcpwm_pkg::*;

    cfg_t      cfg;
    in_item_t  item;
    out_item_t res;
    logic      item_valid;
    logic      take_ok;

    // configuration registers
    tcpwm_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // input register
    tcpwm_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_data),
        .take_ok    (take_ok),
        .item_valid (item_valid),
        .item       (item)
    );

    // timer state and step logic
    tcpwm_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (item_valid && take_ok),
        .item  (item),
        .res   (res)
    );

    // result register
    tcpwm_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .res        (res),
        .take_ok    (take_ok),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_data)
    );

endmodule
